### hw/rtl/obb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package obb_pkg;

    // Field widths
    localparam int AXIS_W   = 16;
    localparam int HALF_W   = 16;
    localparam int CTR_W    = 21;
    localparam int DIFF_W   = 22;
    localparam int L_W      = 32;
    localparam int LIMIT_W  = 29;

    // Input tdata layout, per box
    localparam int BOX_B_BASE  = 255;
    localparam int CTR_OFS     = 0;
    localparam int AXIS_OFS    = 63;
    localparam int HALF_OFS    = 207;
    localparam int VEC48_W     = 48;
    localparam int IN_DATA_W   = 512;
    localparam int OUT_DATA_W  = 8;

    // Axis codes
    localparam int          NUM_AXES = 15;
    localparam logic [3:0]  NO_AXIS  = 4'd15;

    // Register map
    localparam logic        REG_LIMIT   = 1'b0;
    localparam logic [28:0] LIMIT_RESET = 29'd26844;

    typedef logic signed [AXIS_W-1:0] t_comp;
    typedef logic signed [L_W-1:0]    t_lcomp;

endpackage

`default_nettype wire

### hw/rtl/obb_overlap_test.sv
// Throughput: one box pair per cycle while the result stream is not stalled;
// each of the seven stages advances whenever the stage after it is empty or advancing.
// Stages: unpack, axis build, products, dot sums, half-size scaling,
// 69-bit compare, then a priority encoder for the first separating axis.
// Reset (synchronous, active low) empties the pipeline and loads limit 26844.
`timescale 1ns / 1ps
`default_nettype none

module obb_overlap_test
    import obb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Box pair stream
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // a_center[62:0], a_axis_x[110:63], a_axis_y[158:111], a_axis_z[206:159],
    // a_half_size[254:207], b_center[317:255], b_axis_x[365:318],
    // b_axis_y[413:366], b_axis_z[461:414], b_half_size[509:462], zeros
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // overlap[0], separating_axis[4:1], zeros[7:5]
    output      logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready
);

    logic [LIMIT_W-1:0] r_limit;
    logic [7:1]         r_v;
    logic [8:1]         en;

    // Stage 1: unpacked input
    t_comp              r1_ax [2][3][3];
    logic [HALF_W-1:0]  r1_hs [2][3];
    logic signed [DIFF_W-1:0] r1_d [3];
    // Stage 2: candidate axes
    t_lcomp             r2_l [NUM_AXES][3];
    t_comp              r2_ax [2][3][3];
    logic [HALF_W-1:0]  r2_hs [2][3];
    logic signed [DIFF_W-1:0] r2_d [3];
    // Stage 3: products
    logic [62:0]        r3_sq [NUM_AXES][3];
    logic signed [47:0] r3_pa [NUM_AXES][2][3][3];
    logic signed [53:0] r3_pd [NUM_AXES][3];
    logic [HALF_W-1:0]  r3_hs [2][3];
    // Stage 4: sums
    logic [63:0]        r4_len2 [NUM_AXES];
    logic [48:0]        r4_adot [NUM_AXES][2][3];
    logic [54:0]        r4_dl [NUM_AXES];
    logic [HALF_W-1:0]  r4_hs [2][3];
    // Stage 5: scaled half extents
    logic               r5_degen [NUM_AXES];
    logic [63:0]        r5_hp [NUM_AXES][2][3];
    logic [54:0]        r5_dl [NUM_AXES];
    // Stage 6: per-axis verdict
    logic [NUM_AXES-1:0] r6_ovl;
    // Stage 7: result
    logic               r7_overlap;
    logic [3:0]         r7_sep;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        en[8] = m_axis_tready;
        for (int s = 7; s >= 1; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign s_axis_tready = en[1];
    assign m_axis_tvalid = r_v[7];
    assign m_axis_tdata  = {3'b000, r7_sep, r7_overlap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= s_axis_tvalid;
            for (int s = 2; s <= 7; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_LIMIT) ? {3'b000, r_limit} : 32'd0;

    // Stage 1: unpack and form the center difference
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int b = 0; b < 2; b++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int c = 0; c < 3; c++) begin
                        r1_ax[b][k][c] <= s_axis_tdata[b*BOX_B_BASE + AXIS_OFS
                                          + k*VEC48_W + c*AXIS_W +: AXIS_W];
                    end
                    r1_hs[b][k] <= s_axis_tdata[b*BOX_B_BASE + HALF_OFS
                                   + k*HALF_W +: HALF_W];
                end
            end
            for (int c = 0; c < 3; c++) begin
                r1_d[c] <= DIFF_W'($signed(s_axis_tdata[BOX_B_BASE + c*CTR_W +: CTR_W]))
                         - DIFF_W'($signed(s_axis_tdata[c*CTR_W +: CTR_W]));
            end
        end
    end

    // Stage 2: face axes scaled to 2^-28, cross axes from component products
    always_ff @(posedge i_clk) begin
        logic signed [31:0] t_a;
        logic signed [31:0] t_b;
        if (en[2]) begin
            for (int b = 0; b < 2; b++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int c = 0; c < 3; c++) begin
                        r2_l[3*b+k][c] <= {{2{r1_ax[b][k][c][AXIS_W-1]}},
                                           r1_ax[b][k][c], 14'd0};
                    end
                end
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int c = 0; c < 3; c++) begin
                        t_a = 32'(r1_ax[0][i][(c+1)%3]) * 32'(r1_ax[1][j][(c+2)%3]);
                        t_b = 32'(r1_ax[0][i][(c+2)%3]) * 32'(r1_ax[1][j][(c+1)%3]);
                        r2_l[6+3*i+j][c] <= t_a - t_b;
                    end
                end
            end
            r2_ax <= r1_ax;
            r2_hs <= r1_hs;
            r2_d  <= r1_d;
        end
    end

    // Stage 3: squares and projection products
    always_ff @(posedge i_clk) begin
        logic signed [63:0] t_sq;
        if (en[3]) begin
            for (int n = 0; n < NUM_AXES; n++) begin
                for (int c = 0; c < 3; c++) begin
                    t_sq = 64'(r2_l[n][c]) * 64'(r2_l[n][c]);
                    r3_sq[n][c] <= t_sq[62:0];
                    r3_pd[n][c] <= 54'(r2_d[c]) * 54'(r2_l[n][c]);
                    for (int b = 0; b < 2; b++) begin
                        for (int k = 0; k < 3; k++) begin
                            r3_pa[n][b][k][c] <= 48'(r2_ax[b][k][c]) * 48'(r2_l[n][c]);
                        end
                    end
                end
            end
            r3_hs <= r2_hs;
        end
    end

    // Stage 4: squared length and absolute dot products
    always_ff @(posedge i_clk) begin
        logic signed [49:0] t_dot;
        logic signed [55:0] t_dl;
        if (en[4]) begin
            for (int n = 0; n < NUM_AXES; n++) begin
                r4_len2[n] <= 64'(r3_sq[n][0]) + 64'(r3_sq[n][1]) + 64'(r3_sq[n][2]);
                t_dl = 56'(r3_pd[n][0]) + 56'(r3_pd[n][1]) + 56'(r3_pd[n][2]);
                r4_dl[n] <= t_dl[55] ? 55'(-t_dl) : t_dl[54:0];
                for (int b = 0; b < 2; b++) begin
                    for (int k = 0; k < 3; k++) begin
                        t_dot = 50'(r3_pa[n][b][k][0]) + 50'(r3_pa[n][b][k][1])
                              + 50'(r3_pa[n][b][k][2]);
                        r4_adot[n][b][k] <= t_dot[49] ? 49'(-t_dot) : t_dot[48:0];
                    end
                end
            end
            r4_hs <= r3_hs;
        end
    end

    // Stage 5: degenerate check and half-size scaling
    always_ff @(posedge i_clk) begin
        logic [64:0] t_hp;
        if (en[5]) begin
            for (int n = 0; n < NUM_AXES; n++) begin
                r5_degen[n] <= r4_len2[n] < {7'd0, r_limit, 28'd0};
                r5_dl[n]    <= r4_dl[n];
                for (int b = 0; b < 2; b++) begin
                    for (int k = 0; k < 3; k++) begin
                        t_hp = 65'(r4_hs[b][k]) * 65'(r4_adot[n][b][k]);
                        r5_hp[n][b][k] <= t_hp[63:0];
                    end
                end
            end
        end
    end

    // Stage 6: compare projected distance with projected radius; degenerate axes count as overlapping
    always_ff @(posedge i_clk) begin
        logic [66:0] t_rhs;
        if (en[6]) begin
            for (int n = 0; n < NUM_AXES; n++) begin
                t_rhs = 67'(r5_hp[n][0][0]) + 67'(r5_hp[n][0][1]) + 67'(r5_hp[n][0][2])
                      + 67'(r5_hp[n][1][0]) + 67'(r5_hp[n][1][1]) + 67'(r5_hp[n][1][2]);
                r6_ovl[n] <= r5_degen[n] || ({r5_dl[n], 14'd0} < 69'(t_rhs));
            end
        end
    end

    // Stage 7: pick the first separating axis
    always_ff @(posedge i_clk) begin
        logic [3:0] t_sep;
        if (en[7]) begin
            t_sep = NO_AXIS;
            for (int n = NUM_AXES-1; n >= 0; n--) begin
                if (!r6_ovl[n]) t_sep = 4'(n);
            end
            r7_sep     <= t_sep;
            r7_overlap <= &r6_ovl;
        end
    end

    // Overlap flag agrees with the axis code
    a_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[7] |-> (r7_overlap == (r7_sep == NO_AXIS)))
        else $error("overlap flag and separating axis disagree");

    // Input stalls only when the whole pipeline is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_v))
        else $error("input stalled with a bubble in the pipeline");

    // Limit register takes the written value
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_LIMIT))
        |=> (r_limit == $past(pwdata[LIMIT_W-1:0])))
        else $error("limit register write lost");

    // Reset loads the default limit
    a_reset_limit: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_limit == LIMIT_RESET))
        else $error("limit not at reset value");

endmodule

`default_nettype wire

### dv/obb_overlap_test_test.sv
`timescale 1ns / 1ps

module obb_overlap_test_test;
    import obb_pkg::*;

    typedef struct packed {
        logic       overlap;
        logic [3:0] sep_axis;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    obb_overlap_test uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    logic [IN_DATA_W-1:0] pair_q[$];
    t_verdict             verdict_q[$];
    logic [28:0]          axis_limit = LIMIT_RESET;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_off = 0;
    logic                 hold_req = 1'b0;
    logic                 hold_ack = 1'b0;
    int                   n_fail = 0;
    int                   n_sent = 0;
    int                   n_results = 0;
    int                   n_overlap = 0;
    int                   idle_cycles = 0;
    logic                 s_axis_tready_q = 1'b0;

    // Queue one box pair for the driver
    task automatic add_pair(logic [IN_DATA_W-1:0] p);
        pair_q.insert(pair_q.size(), p);
    endtask

    // Signed field extraction
    function automatic longint sx(logic [63:0] v, int w);
        longint r;
        r = longint'(v << (64 - w)) >>> (64 - w);
        return r;
    endfunction

    function automatic longint dot3(longint a[3], longint b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Predict overlap and the first separating axis for one box pair
    function automatic t_verdict predict_verdict(logic [IN_DATA_W-1:0] p);
        longint   ax[2][3][3];
        longint   hs[2][3];
        longint   d[3];
        longint   lv[3];
        longint   pa[3];
        longint   qb[3];
        longint   dl;
        logic [127:0] len2;
        logic [127:0] rhs;
        logic [127:0] lhs;
        int       base;
        int       sep;
        t_verdict v;
        sep = int'(NO_AXIS);
        for (int b = 0; b < 2; b++) begin
            base = b * BOX_B_BASE;
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++)
                    ax[b][k][c] = sx(64'(p[base + AXIS_OFS + 48 * k + 16 * c +: 16]), 16);
                hs[b][k] = longint'(p[base + HALF_OFS + 16 * k +: 16]);
            end
        end
        for (int c = 0; c < 3; c++)
            d[c] = sx(64'(p[BOX_B_BASE + 21 * c +: 21]), 21) - sx(64'(p[21 * c +: 21]), 21);
        for (int n = 0; n < NUM_AXES && sep == int'(NO_AXIS); n++) begin
            if (n < 6) begin
                for (int c = 0; c < 3; c++) lv[c] = ax[n / 3][n % 3][c] * 16384;
            end else begin
                pa = ax[0][(n - 6) / 3];
                qb = ax[1][(n - 6) % 3];
                lv[0] = pa[1] * qb[2] - pa[2] * qb[1];
                lv[1] = pa[2] * qb[0] - pa[0] * qb[2];
                lv[2] = pa[0] * qb[1] - pa[1] * qb[0];
            end
            len2 = '0;
            for (int c = 0; c < 3; c++) len2 += 128'(lv[c] * lv[c]);
            if (len2 < (128'(axis_limit) << 28)) continue;
            rhs = '0;
            for (int b = 0; b < 2; b++)
                for (int k = 0; k < 3; k++) begin
                    dl = dot3(ax[b][k], lv);
                    if (dl < 0) dl = -dl;
                    rhs += 128'(hs[b][k]) * 128'(dl);
                end
            dl = dot3(d, lv);
            if (dl < 0) dl = -dl;
            lhs = 128'(dl) << 14;
            if (!(lhs < rhs)) sep = n;
        end
        v.overlap  = (sep == int'(NO_AXIS));
        v.sep_axis = 4'(sep);
        return v;
    endfunction

    // Random axis: a signed unit on one rail, components in [-16384, 16384], or any pattern
    function automatic logic [47:0] rand_axis();
        logic [47:0] a;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            a = '0;
            a[16 * $urandom_range(0, 2) +: 16] = ($urandom_range(0, 1) ? 16'h4000 : 16'hC000);
        end else if (sel < 8) begin
            for (int c = 0; c < 3; c++)
                a[16 * c +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
        end else begin
            a = 48'({$urandom, $urandom});
        end
        return a;
    endfunction

    function automatic logic [62:0] rand_center(int span);
        logic [62:0] c;
        for (int k = 0; k < 3; k++)
            c[21 * k +: 21] = 21'(int'($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 15) == 0) c = 63'({$urandom, $urandom});
        return c;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_pair(logic [62:0] ca, logic [47:0] axa[3],
            logic [47:0] ha, logic [62:0] cb, logic [47:0] axb[3], logic [47:0] hb);
        logic [IN_DATA_W-1:0] p;
        p = '0;
        p[CTR_OFS +: 63] = ca;
        for (int k = 0; k < 3; k++) p[AXIS_OFS + 48 * k +: 48] = axa[k];
        p[HALF_OFS +: 48] = ha;
        p[BOX_B_BASE + CTR_OFS +: 63] = cb;
        for (int k = 0; k < 3; k++) p[BOX_B_BASE + AXIS_OFS + 48 * k +: 48] = axb[k];
        p[BOX_B_BASE + HALF_OFS +: 48] = hb;
        return p;
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_pair();
        logic [47:0] axa[3];
        logic [47:0] axb[3];
        logic [47:0] ha;
        logic [47:0] hb;
        int span;
        span = $urandom_range(0, 3) == 0 ? 1048575 : 2048;
        for (int k = 0; k < 3; k++) begin
            axa[k] = rand_axis();
            axb[k] = rand_axis();
            ha[16 * k +: 16] = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
            hb[16 * k +: 16] = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
        end
        return pack_pair(rand_center(span), axa, ha, rand_center(span), axb, hb);
    endfunction

    // Driver: offer queued pairs, idling at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready_q) begin
            if (pair_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pair_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Handshake seen at the last rising edge
    always @(posedge i_clk) begin
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            verdict_q.insert(verdict_q.size(), predict_verdict(s_axis_tdata));
            n_sent++;
        end
    end

    // Receiver backpressure, with a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_off <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_verdict want;
        if (m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (verdict_q.size() == 0) begin
                $error("result with no prediction pending: %h", m_axis_tdata);
                n_fail++;
            end else begin
                want = verdict_q.pop_front();
                if (want.overlap) n_overlap++;
                if (m_axis_tdata[0] !== want.overlap) begin
                    $error("overlap: expected %0d, got %0d", want.overlap, m_axis_tdata[0]);
                    n_fail++;
                end
                if (m_axis_tdata[4:1] !== want.sep_axis) begin
                    $error("separating_axis: expected %0d, got %0d",
                           want.sep_axis, m_axis_tdata[4:1]);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL obb_overlap_test");
            $finish;
        end
    end

    task automatic apb_write(logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'(REG_LIMIT) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        axis_limit = val[28:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pair_q.size() > 0 || s_axis_tvalid || verdict_q.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) add_pair(rand_pair());
        drain();
    endtask

    initial begin
        logic [47:0] ax0[3];
        logic [47:0] zax[3];
        logic [47:0] hmax;
        ax0[0] = 48'h0000_0000_4000;
        ax0[1] = 48'h0000_4000_0000;
        ax0[2] = 48'h4000_0000_0000;
        zax[0] = '0; zax[1] = '0; zax[2] = '0;
        hmax = '1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: coincident, touching, separated on each face, degenerate axes, extreme values, then random pairs
        add_pair(pack_pair('0, ax0, {3{16'h0100}}, '0, ax0, {3{16'h0100}}));
        add_pair(pack_pair('0, ax0, {3{16'h0100}}, 63'h200, ax0, {3{16'h0100}}));
        add_pair(pack_pair('0, ax0, {3{16'h0100}}, 63'h1FF, ax0, {3{16'h0100}}));
        add_pair(pack_pair('0, ax0, {3{16'h0100}}, 63'h300 << 21, ax0, {3{16'h0100}}));
        add_pair(pack_pair('0, ax0, {3{16'h0100}}, 63'h300 << 42, ax0, {3{16'h0100}}));
        add_pair(pack_pair('0, zax, '0, 63'h300, ax0, '0));
        add_pair(pack_pair('0, zax, '0, 63'h300, zax, '0));
        add_pair(pack_pair({3{21'h0FFFFF}}, ax0, hmax, {3{21'h100000}}, ax0, hmax));
        add_pair(pack_pair({3{21'h100000}}, ax0, '0, {3{21'h0FFFFF}}, ax0, '0));
        add_pair(pack_pair('1, '{48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000,
                48'h7FFF_7FFF_7FFF}, hmax, '1, '{48'h8000_8000_8000,
                48'h7FFF_7FFF_7FFF, 48'hFFFF_FFFF_FFFF}, hmax));
        for (int i = 0; i < 10; i++) add_pair(rand_pair());
        drain();

        // Random phases across idling mixes and limit settings
        run_phase(180, 0, 0);
        apb_write(32'd0);
        run_phase(150, 73, 0);
        apb_write(32'h1000_0000);
        run_phase(100, 0, 73);
        apb_write(32'h1FFF_FFFF);
        run_phase(60, 26, 26);
        apb_write(32'd26844);

        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 60; i++) add_pair(rand_pair());
        hold_req = ~hold_req;
        drain();
        apb_write(32'd1 << $urandom_range(0, 27));
        run_phase(180, 26, 26);

        $display("Checked %0d of %0d box pairs (%0d overlapping) over five limit settings",
                 n_results, n_sent, n_overlap);
        $display("with random source idling, sink stalls and one long sink hold-off.");
        if (n_fail == 0 && verdict_q.size() == 0) begin
            $display("PASS obb_overlap_test");
        end else begin
            $display("FAIL obb_overlap_test");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/obb_pkg.sv
hw/rtl/obb_overlap_test.sv
dv/obb_overlap_test_test.sv
